[rtl/epc_pkg.sv]
package epc_pkg;

  localparam logic [31:0] EpochShift = 32'd946656000;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [16:0] SecsPerDay = 17'd86400;
  localparam logic [11:0] FirstYear = 12'd2000;
  // Days from 2000-01-01 to 2100-01-01; from there on the year is out of range.
  localparam logic [15:0] CenturyDays = 16'd36525;
  localparam logic [10:0] FourYearDays = 11'd1461;
  localparam logic [8:0] LeapDays = 9'd366;
  localparam logic [8:0] PlainDays = 9'd365;

  // Reciprocals for division by constants, each followed by a small correction
  // or exact over the value range in use.
  localparam logic [25:0] RecipDay = 26'd50903316;   // 2^35 / 675, rounded down
  localparam logic [12:0] RecipHour = 13'd4661;      // 2^20 / 225, rounded up
  localparam logic [15:0] RecipCycle = 16'd45934;    // 2^26 / 1461, rounded up
  localparam logic [10:0] RecipMin = 11'd1093;       // 2^14 / 15, rounded up

  typedef struct packed {
    logic        vld;
    logic [15:0] days;
    logic [16:0] sod;
  } day_beat_t;

  // Day of year on which a month starts, in a plain year.
  function automatic logic [8:0] month_start(input logic [3:0] mon);
    logic [8:0] s;
    case (mon)
      4'd0: s = 9'd0;
      4'd1: s = 9'd31;
      4'd2: s = 9'd59;
      4'd3: s = 9'd90;
      4'd4: s = 9'd120;
      4'd5: s = 9'd151;
      4'd6: s = 9'd181;
      4'd7: s = 9'd212;
      4'd8: s = 9'd243;
      4'd9: s = 9'd273;
      4'd10: s = 9'd304;
      4'd11: s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

[rtl/epc_day_div.sv]
module epc_day_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [31:0]          seconds_count_i,
  input  logic [7:0]           zone_hours_i,
  output epc_pkg::day_beat_t   beat_o
);

  logic        v1_q, v2_q, v3_q, v4_q;
  logic [31:0] local1_q, local2_q, local3_q;
  logic [15:0] q2_q, q3_q;
  logic [24:0] p3_q;
  logic [15:0] days4_q;
  logic [16:0] sod4_q;

  logic [19:0] zone_secs;
  logic [31:0] local1_d;
  logic [50:0] prod2;
  logic [34:0] prod3;
  logic [24:0] rem4;
  logic        fix4;
  logic [31:0] sod_raw;
  logic [31:0] sod_fix;

  assign zone_secs = zone_hours_i * epc_pkg::SecsPerHour;
  assign local1_d = seconds_count_i - epc_pkg::EpochShift + {12'd0, zone_secs};
  assign prod2 = local1_q[31:7] * epc_pkg::RecipDay;
  assign prod3 = q2_q * 19'd675;
  assign rem4 = local3_q[31:7] - p3_q;
  // The reciprocal estimate is at most one short.
  assign fix4 = (rem4 >= 25'd675);
  assign sod_raw = local3_q - {p3_q, 7'd0};
  assign sod_fix = fix4 ? sod_raw - {15'd0, epc_pkg::SecsPerDay} : sod_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      local1_q <= local1_d;
      local2_q <= local1_q;
      q2_q     <= prod2[50:35];
      local3_q <= local2_q;
      q3_q     <= q2_q;
      p3_q     <= prod3[24:0];
      days4_q  <= fix4 ? q3_q + 16'd1 : q3_q;
      sod4_q   <= sod_fix[16:0];
    end
  end

  assign beat_o.vld = v4_q;
  assign beat_o.days = days4_q;
  assign beat_o.sod = sod4_q;

endmodule

[rtl/epc_cal.sv]
module epc_cal (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  epc_pkg::day_beat_t   beat_i,
  output logic                 valid_o,
  output logic [11:0]          year_value_o,
  output logic [3:0]           month_value_o,
  output logic [4:0]           day_value_o,
  output logic [4:0]           hour_value_o,
  output logic [5:0]           minute_value_o,
  output logic [5:0]           second_value_o,
  output logic                 range_error_o
);

  logic        v5_q, v6_q, v7_q, v8_q;
  logic [16:0] sod5_q;
  logic [15:0] days5_q;
  logic [4:0]  h5_q, h6_q, h7_q;
  logic [5:0]  c5_q, c6_q;
  logic        err5_q, err6_q, err7_q;
  logic [11:0] rest6_q, rest7_q;
  logic [10:0] rem6_q;
  logic [5:0]  m7_q;
  logic [8:0]  doy7_q;
  logic        leap7_q;
  logic [11:0] year7_q;
  logic [11:0] year8_q;
  logic [3:0]  mon8_q;
  logic [4:0]  day8_q;
  logic [4:0]  h8_q;
  logic [5:0]  m8_q, s8_q;
  logic        err8_q;

  logic [25:0] hprod;
  logic [31:0] cprod;
  logic [16:0] rest_w;
  logic [15:0] rem_w;
  logic [20:0] mprod;
  logic [10:0] rem2;
  logic [1:0]  r1;
  logic [10:0] doy_w;
  logic [1:0]  yoff;
  logic [11:0] sec_w;
  logic [3:0]  mcount;
  logic [8:0]  start;
  logic [8:0]  mstart;
  logic [8:0]  dom;

  assign hprod = beat_i.sod[16:4] * epc_pkg::RecipHour;
  assign cprod = beat_i.days * epc_pkg::RecipCycle;

  assign rest_w = sod5_q - h5_q * epc_pkg::SecsPerHour;
  assign rem_w = days5_q - c5_q * epc_pkg::FourYearDays;

  assign mprod = rest6_q[11:2] * epc_pkg::RecipMin;
  assign rem2 = rem6_q - {2'd0, epc_pkg::LeapDays};
  assign r1 = (rem2 >= 11'd730) ? 2'd2 : ((rem2 >= 11'd365) ? 2'd1 : 2'd0);
  assign doy_w = (rem6_q < {2'd0, epc_pkg::LeapDays}) ? rem6_q
               : rem2 - r1 * {2'd0, epc_pkg::PlainDays};
  assign yoff = (rem6_q < {2'd0, epc_pkg::LeapDays}) ? 2'd0 : r1 + 2'd1;

  assign sec_w = rest7_q - m7_q * 12'd60;

  // Month is the number of month starts at or before the day of year.
  always_comb begin
    mcount = 4'd0;
    mstart = 9'd0;
    for (int k = 1; k < 12; k++) begin
      start = epc_pkg::month_start(4'(k)) + ((leap7_q && k >= 2) ? 9'd1 : 9'd0);
      if (doy7_q >= start) begin
        mcount = 4'(k);
        mstart = start;
      end
    end
  end
  assign dom = doy7_q - mstart + 9'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= beat_i.vld;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sod5_q  <= beat_i.sod;
      days5_q <= beat_i.days;
      h5_q    <= hprod[24:20];
      c5_q    <= cprod[31:26];
      err5_q  <= (beat_i.days >= epc_pkg::CenturyDays);

      h6_q    <= h5_q;
      c6_q    <= c5_q;
      err6_q  <= err5_q;
      rest6_q <= rest_w[11:0];
      rem6_q  <= rem_w[10:0];

      h7_q    <= h6_q;
      err7_q  <= err6_q;
      rest7_q <= rest6_q;
      m7_q    <= mprod[19:14];
      doy7_q  <= doy_w[8:0];
      leap7_q <= (rem6_q < {2'd0, epc_pkg::LeapDays});
      year7_q <= epc_pkg::FirstYear + {4'd0, c6_q, 2'd0} + {10'd0, yoff};

      h8_q    <= h7_q;
      m8_q    <= m7_q;
      s8_q    <= sec_w[5:0];
      err8_q  <= err7_q;
      year8_q <= err7_q ? 12'd0 : year7_q;
      mon8_q  <= err7_q ? 4'd0 : mcount + 4'd1;
      day8_q  <= err7_q ? 5'd0 : dom[4:0];
    end
  end

  assign valid_o = v8_q;
  assign year_value_o = year8_q;
  assign month_value_o = mon8_q;
  assign day_value_o = day8_q;
  assign hour_value_o = h8_q;
  assign minute_value_o = m8_q;
  assign second_value_o = s8_q;
  assign range_error_o = err8_q;

endmodule

[rtl/epoch_to_calendar_date.sv]
// Throughput: one beat per cycle while the output is not stalled; the eight-stage
// multiply-and-correct pipeline sets the figure, and a stalled output holds every
// stage in place.
// Reset: rst_ni clears all valid bits asynchronously; data registers are not
// reset and no result is shown until a beat has passed through.
module epoch_to_calendar_date (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] seconds_count_i,
  input  logic [7:0]  zone_hours_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] year_value_o,
  output logic [3:0]  month_value_o,
  output logic [4:0]  day_value_o,
  output logic [4:0]  hour_value_o,
  output logic [5:0]  minute_value_o,
  output logic [5:0]  second_value_o,
  output logic        range_error_o
);

  logic               en;
  epc_pkg::day_beat_t day_beat;

  // The whole pipeline moves together unless a finished beat is held.
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  epc_day_div u_day_div (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (in_valid_i),
    .seconds_count_i(seconds_count_i),
    .zone_hours_i   (zone_hours_i),
    .beat_o         (day_beat)
  );

  epc_cal u_cal (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .beat_i        (day_beat),
    .valid_o       (out_valid_o),
    .year_value_o  (year_value_o),
    .month_value_o (month_value_o),
    .day_value_o   (day_value_o),
    .hour_value_o  (hour_value_o),
    .minute_value_o(minute_value_o),
    .second_value_o(second_value_o),
    .range_error_o (range_error_o)
  );

endmodule
